// File: src/msprc_pkg.sv
// Package with frame constants, register codes and byte helpers for the RC frame encoder.
package msprc_pkg;

    localparam int CHANNELS_DEF = 14;
    localparam int MAX_BYTES    = 10;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_V1  = 2'd1;
    localparam logic [1:0] MODE_V2  = 2'd2;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_CMD  = 2'd1;

    localparam logic [7:0] CMD_RESET = 8'hc8;
    localparam logic [7:0] CRC_POLY  = 8'hd5;
    localparam logic [7:0] SYNC_DOLLAR = 8'h24;
    localparam logic [7:0] SYNC_V1     = 8'h4d;
    localparam logic [7:0] SYNC_V2     = 8'h58;
    localparam logic [7:0] SYNC_DIR    = 8'h3c;

    localparam logic [3:0] HDR_LEN_V1 = 4'd5;
    localparam logic [3:0] HDR_LEN_V2 = 4'd8;
    localparam logic [3:0] HDR_CHECKED_FROM = 4'd3;

    // CRC-8 DVB-S2 update over one byte.
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Header byte at position k.
    function automatic logic [7:0] hdr_byte(input logic v2, input logic [3:0] k,
                                            input logic [7:0] cmd, input logic [7:0] size);
        logic [7:0] b;
        b = 8'h00;
        case (k)
            4'd0: b = SYNC_DOLLAR;
            4'd1: b = v2 ? SYNC_V2 : SYNC_V1;
            4'd2: b = SYNC_DIR;
            4'd3: b = v2 ? 8'h00 : size;
            4'd4: b = cmd;
            4'd5: b = 8'h00;
            4'd6: b = size;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: src/msp_rc_frame_encoder_core.sv
// RC frame encoder: MSPv1/MSPv2 framing of channel values, one output byte per cycle unless stalled.
//
// Each accepted channel request is held in an item register and sent out through a
// registered byte port, one byte per cycle while out_ready does not stall it. A channel
// gives 2 bytes, plus the check byte on the last channel of a frame, plus 5 (MSPv1) or
// 8 (MSPv2) header bytes on the first channel; with 14 channels a frame has 34 or 37 bytes.
// The byte sequencer sets the rate: the next channel is taken in the same cycle that the
// final byte of the current one moves to the output register, so requests follow
// without gaps. In mode 0 (or 3) requests are taken at once and produce no bytes. A
// write to the mode register restarts the frame.
module msp_rc_frame_encoder_core #(
    parameter int CHANNELS = msprc_pkg::CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] channel_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        run_last,
    output logic        frame_end
);
    import msprc_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);
    localparam logic [7:0] FRAME_SIZE = 8'(2 * CHANNELS);

    logic [1:0]       mode_reg;
    logic [7:0]       cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       check_reg;

    logic             item_valid_reg;
    logic [15:0]      item_ch_reg;
    logic             item_v2_reg;
    logic [7:0]       item_cmd_reg;
    logic             item_first_reg;
    logic             item_last_reg;
    logic [3:0]       step_reg;

    logic             out_valid_reg;
    logic [7:0]       byte_reg;
    logic             run_last_reg;
    logic             frame_end_reg;

    logic             mode_ok;
    logic             accept;
    logic             out_free;
    logic             emit;
    logic             item_done;
    logic [3:0]       pre_len;
    logic [3:0]       total;
    logic [3:0]       pay_pos;
    logic             is_final;
    logic             in_hdr;
    logic             checked;
    logic             is_check;
    logic [7:0]       cur_byte;
    logic [7:0]       check_next;

    assign mode_ok   = (mode_reg == MODE_V1) || (mode_reg == MODE_V2);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        pre_len = item_first_reg ? (item_v2_reg ? HDR_LEN_V2 : HDR_LEN_V1) : 4'd0;
        total   = pre_len + 4'd2 + {3'd0, item_last_reg};
        if (total > 4'(MAX_BYTES))
        begin
            total = 4'(MAX_BYTES);
        end
        in_hdr   = step_reg < pre_len;
        pay_pos  = step_reg - pre_len;
        is_final = step_reg == (total - 4'd1);
        is_check = 1'b0;
        checked  = 1'b0;
        cur_byte = 8'h00;
        if (in_hdr)
        begin
            cur_byte = hdr_byte(item_v2_reg, step_reg, item_cmd_reg, FRAME_SIZE);
            checked  = step_reg >= HDR_CHECKED_FROM;
        end
        else
        begin
            case (pay_pos)
                4'd0:
                begin
                    cur_byte = item_ch_reg[15:8];
                    checked  = 1'b1;
                end
                4'd1:
                begin
                    cur_byte = item_ch_reg[7:0];
                    checked  = 1'b1;
                end
                default:
                begin
                    cur_byte = check_reg;
                    is_check = 1'b1;
                end
            endcase
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = item_valid_reg && out_free;
    assign item_done = emit && is_final;
    assign in_ready  = !item_valid_reg || item_done;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        check_next = check_reg;
        if (cfg_valid && cfg_index == REG_MODE)
        begin
            check_next = 8'h00;
        end
        else if (accept && !mode_ok)
        begin
            check_next = 8'h00;
        end
        else if (emit)
        begin
            if (is_final && item_last_reg)
            begin
                check_next = 8'h00;
            end
            else if (checked)
            begin
                check_next = item_v2_reg ? crc_step(check_reg, cur_byte)
                                         : (check_reg ^ cur_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_OFF;
            cmd_reg        <= CMD_RESET;
            idx_reg        <= '0;
            check_reg      <= 8'h00;
            item_valid_reg <= 1'b0;
            step_reg       <= 4'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            check_reg <= check_next;

            if (cfg_valid && cfg_index == REG_MODE)
            begin
                mode_reg <= cfg_data[1:0];
            end
            else if (cfg_valid && cfg_index == REG_CMD)
            begin
                cmd_reg <= cfg_data;
            end

            if (cfg_valid && cfg_index == REG_MODE)
            begin
                idx_reg <= '0;
            end
            else if (accept)
            begin
                idx_reg <= (mode_ok && idx_reg != IDX_LAST) ? idx_reg + 1'b1 : '0;
            end

            if (accept && mode_ok)
            begin
                item_valid_reg <= 1'b1;
                step_reg       <= 4'd0;
            end
            else
            begin
                if (emit)
                begin
                    step_reg <= step_reg + 4'd1;
                end
                if (item_done)
                begin
                    item_valid_reg <= 1'b0;
                end
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_ch_reg    <= channel_value;
            item_v2_reg    <= mode_reg == MODE_V2;
            item_cmd_reg   <= cmd_reg;
            item_first_reg <= idx_reg == '0;
            item_last_reg  <= idx_reg == IDX_LAST;
        end
        if (emit)
        begin
            byte_reg      <= cur_byte;
            run_last_reg  <= is_final;
            frame_end_reg <= is_check;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign run_last   = run_last_reg;
    assign frame_end  = frame_end_reg;

endmodule

// File: bench/msp_rc_frame_checker.sv
// Checker for the RC frame encoder: tracks register writes, predicts frame bytes, compares output.
module msp_rc_frame_checker
    import msprc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] channel_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  frame_byte,
    input  logic        run_last,
    input  logic        frame_end,
    output int          mismatch_count,
    output int          pending_bytes
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fend;
    } enc_byte_t;

    enc_byte_t  expected_bytes[$];
    enc_byte_t  channel_run[$];
    enc_byte_t  want;

    logic [1:0] mode_q  = MODE_OFF;
    logic [7:0] cmd_q   = CMD_RESET;
    logic [3:0] slot_q  = '0;
    logic [7:0] check_q = '0;

    function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        repeat (8)
        begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("frame byte %0d: %s got %0h expected %0h", expected_bytes.size(), what,
                 got, exp_val);
        mismatch_count++;
    endtask

    task automatic emit(input logic [7:0] b, input bit folded);
        if (folded)
        begin
            check_q = (mode_q == MODE_V1) ? (check_q ^ b) : crc8_update(check_q, b);
        end
        channel_run.push_back({b, 1'b0, 1'b0});
    endtask

    task automatic encode_channel(input logic [15:0] value);
        logic [7:0] frame_size;
        frame_size = 8'(2 * CHANNELS_DEF);
        channel_run.delete();
        if (mode_q != MODE_V1 && mode_q != MODE_V2)
        begin
            slot_q  = '0;
            check_q = '0;
            return;
        end
        if (slot_q == '0)
        begin
            check_q = '0;
            emit(SYNC_DOLLAR, 1'b0);
            emit((mode_q == MODE_V1) ? SYNC_V1 : SYNC_V2, 1'b0);
            emit(SYNC_DIR, 1'b0);
            if (mode_q == MODE_V1)
            begin
                emit(frame_size, 1'b1);
                emit(cmd_q, 1'b1);
            end
            else
            begin
                emit(8'h00, 1'b1);
                emit(cmd_q, 1'b1);
                emit(8'h00, 1'b1);
                emit(frame_size, 1'b1);
                emit(8'h00, 1'b1);
            end
        end
        emit(value[15:8], 1'b1);
        emit(value[7:0], 1'b1);
        if (int'(slot_q) + 1 >= CHANNELS_DEF)
        begin
            channel_run.push_back({check_q, 1'b0, 1'b1});
            slot_q  = '0;
            check_q = '0;
        end
        else
        begin
            slot_q = slot_q + 4'd1;
        end
        // drop bytes past the per-request limit
        while (channel_run.size() > MAX_BYTES)
        begin
            void'(channel_run.pop_back());
        end
        if (channel_run.size() > 0)
        begin
            channel_run[channel_run.size() - 1].last = 1'b1;
        end
        foreach (channel_run[i])
        begin
            expected_bytes.push_back(channel_run[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q         = MODE_OFF;
            cmd_q          = CMD_RESET;
            slot_q         = '0;
            check_q        = '0;
            mismatch_count = 0;
            expected_bytes.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("unexpected byte", frame_byte, 0);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (frame_byte !== want.data)
                    begin
                        report_mismatch("frame_byte", frame_byte, want.data);
                    end
                    if (run_last !== want.last)
                    begin
                        report_mismatch("run_last", run_last, want.last);
                    end
                    if (frame_end !== want.fend)
                    begin
                        report_mismatch("frame_end", frame_end, want.fend);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MODE)
                begin
                    mode_q  = cfg_data[1:0];
                    slot_q  = '0;
                    check_q = '0;
                end
                else if (cfg_index == REG_CMD)
                begin
                    cmd_q = cfg_data;
                end
            end
            if (in_valid && in_ready)
            begin
                encode_channel(channel_value);
            end
        end
        pending_bytes = expected_bytes.size();
    end

endmodule

// File: bench/msp_rc_frame_encoder_core_test.sv
// Testbench top for the RC frame encoder: clock, reset, stimulus, stalls and verdict.
module msp_rc_frame_encoder_core_test;
    import msprc_pkg::*;

    localparam logic [1:0] MODE_BAD     = 2'd3;
    localparam logic [1:0] REG_SPARE_LO = 2'd2;
    localparam logic [1:0] REG_SPARE_HI = 2'd3;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int TARGET_ITEMS  = 180;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = '0;
    logic [7:0]  cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [15:0] channel_value = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [7:0]  frame_byte;
    logic        run_last;
    logic        frame_end;

    int mismatch_count;
    int pending_bytes;
    int sender_pct   = 0;
    int receiver_pct = 0;
    int quiet_cycles = 0;
    bit hold_req     = 1'b0;

    msp_rc_frame_encoder_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .channel_value (channel_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .run_last      (run_last),
        .frame_end     (frame_end)
    );

    msp_rc_frame_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .channel_value  (channel_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_byte     (frame_byte),
        .run_last       (run_last),
        .frame_end      (frame_end),
        .mismatch_count (mismatch_count),
        .pending_bytes  (pending_bytes)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // receiver: random stalls, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= receiver_pct);
            end
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic set_idling(input idle_mode_t m);
        sender_pct   = (m == IDLE_SENDER) ? 55 : (m == IDLE_BOTH) ? 21 : 0;
        receiver_pct = (m == IDLE_RECEIVER) ? 55 : (m == IDLE_BOTH) ? 21 : 0;
    endtask

    task automatic cfg_write(input logic [1:0] index, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_channel(input logic [15:0] value);
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < sender_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        channel_value <= value;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    // hold off until every predicted byte is out, then let the block settle
    task automatic drain();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_bytes != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_channel();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] corner_values[14];
        logic [1:0]  next_mode;
        int          counted;
        int          phase;
        int          n;
        int          pick;
        bit          mid_write;

        corner_values = '{16'h0000, 16'hffff, 16'h8000, 16'h0001, 16'h00ff, 16'hff00,
                          16'h7fff, 16'hfffe, 16'h5555, 16'haaaa, 16'h1234,
                          16'h0000, 16'hffff, 16'h0000};
        corner_values[13] = 16'($urandom);
        counted = 0;
        phase   = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(IDLE_NONE);
        send_channel(16'h0000);
        send_channel(16'hffff);
        drain();
        cfg_write(REG_MODE, {6'd0, MODE_V1});
        foreach (corner_values[i])
        begin
            send_channel(corner_values[i]);
        end
        drain();
        cfg_write(REG_MODE, {6'h3f, MODE_V2});
        cfg_write(REG_CMD, 8'hff);
        repeat (3) send_channel(pick_channel());
        drain();
        cfg_write(REG_CMD, 8'h00);
        cfg_write(REG_SPARE_LO, 8'ha5);
        cfg_write(REG_SPARE_HI, 8'h5a);
        repeat (2) send_channel(pick_channel());
        drain();
        cfg_write(REG_MODE, {6'h2a, MODE_BAD});
        repeat (2) send_channel(pick_channel());
        drain();

        while (counted < TARGET_ITEMS)
        begin
            set_idling(idle_mode_t'(phase % 4));
            pick = $urandom_range(0, 9);
            next_mode = (pick < 4) ? MODE_V1 : (pick < 8) ? MODE_V2 :
                        (pick == 8) ? MODE_OFF : MODE_BAD;
            pick = $urandom_range(0, 9);
            n = (pick < 6) ? CHANNELS_DEF : (pick < 8) ? 2 * CHANNELS_DEF :
                $urandom_range(1, CHANNELS_DEF - 1);
            if (phase == 2)
            begin
                next_mode = MODE_V2;
                n = 2 * CHANNELS_DEF;
            end
            if (phase % 4 != 3 || phase == 2)
            begin
                cfg_write(REG_MODE, {6'($urandom), next_mode});
            end
            cfg_write(REG_CMD, pick_command());
            if ($urandom_range(0, 3) == 0)
            begin
                cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 8'($urandom));
            end
            if (phase == 2)
            begin
                hold_req = 1'b1;
            end
            mid_write = (phase % 3 == 1) && (n >= CHANNELS_DEF);
            for (int i = 0; i < n; i++)
            begin
                if (mid_write && i == CHANNELS_DEF / 2)
                begin
                    drain();
                    cfg_write(REG_CMD, pick_command());
                end
                send_channel(pick_channel());
            end
            counted += n;
            drain();
            phase++;
        end

        set_idling(IDLE_NONE);
        drain();
        if (mismatch_count == 0 && pending_bytes == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
src/msprc_pkg.sv
src/msp_rc_frame_encoder_core.sv
bench/msp_rc_frame_checker.sv
bench/msp_rc_frame_encoder_core_test.sv
